FILE: hw/rtl/bavg_pkg.sv
// Shared types and constants for the box-average RGB565 to RGB555 unit.
// No dependencies; imported by all bavg modules.
`timescale 1ns / 1ps

package bavg_pkg;

  // One output channel is five bits, so every box average is a 5-bit quotient.
  localparam int CH_W   = 5;
  localparam int QUO_W  = CH_W;
  localparam int STEP_W = $clog2(QUO_W);
  localparam int PIX_IN_W  = 16;
  localparam int PIX_OUT_W = 3 * CH_W;
  localparam int SIDE_CFG_W = 6;

  // Field positions in the source word.
  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 6;
  localparam int BLUE_LSB  = 0;

  // Field positions in the result word.
  localparam int OUT_RED_LSB   = 10;
  localparam int OUT_GREEN_LSB = 5;
  localparam int OUT_BLUE_LSB  = 0;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic box_full;
  } acc_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: hw/rtl/bavg_acc.sv
// Channel sums, pixel count and box-area compare for the box-average unit.
// Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_acc #(
  parameter int MAX_BOX_SIDE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bavg_pkg::acc_ctrl_t                 ctrl,
  input  logic [bavg_pkg::PIX_IN_W-1:0]       pixel,
  input  logic [bavg_pkg::SIDE_CFG_W-1:0]     box_side,
  output bavg_pkg::acc_status_t               st,
  output logic [$clog2(31*MAX_BOX_SIDE*MAX_BOX_SIDE+1)-1:0] red_sum,
  output logic [$clog2(31*MAX_BOX_SIDE*MAX_BOX_SIDE+1)-1:0] green_sum,
  output logic [$clog2(31*MAX_BOX_SIDE*MAX_BOX_SIDE+1)-1:0] blue_sum,
  output logic [$clog2(MAX_BOX_SIDE*MAX_BOX_SIDE+1)-1:0]    count
);
  import bavg_pkg::*;

  localparam int SUM_W  = $clog2(31*MAX_BOX_SIDE*MAX_BOX_SIDE+1);
  localparam int CNT_W  = $clog2(MAX_BOX_SIDE*MAX_BOX_SIDE+1);
  localparam int SIDE_W = $clog2(MAX_BOX_SIDE+1);

  logic [SUM_W-1:0]      red_r, red_nxt;
  logic [SUM_W-1:0]      green_r, green_nxt;
  logic [SUM_W-1:0]      blue_r, blue_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SIDE_CFG_W:0]   side_clamp;
  logic [SIDE_W-1:0]     side;
  logic [2*SIDE_W-1:0]   area_full;
  logic [CNT_W-1:0]      area;

  // side 0 behaves as 1, anything past the maximum saturates
  always_comb begin
    side_clamp = {1'b0, box_side};
    if (box_side == '0) begin
      side_clamp = (SIDE_CFG_W+1)'(1);
    end else if ({1'b0, box_side} > (SIDE_CFG_W+1)'(MAX_BOX_SIDE)) begin
      side_clamp = (SIDE_CFG_W+1)'(MAX_BOX_SIDE);
    end
    side      = SIDE_W'(side_clamp);
    area_full = side * side;
    area      = area_full[CNT_W-1:0];
  end

  always_comb begin
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    cnt_nxt   = cnt_r;
    if (ctrl.clear) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
      cnt_nxt   = '0;
    end else if (ctrl.add) begin
      red_nxt   = red_r   + SUM_W'(pixel[RED_LSB   +: CH_W]);
      green_nxt = green_r + SUM_W'(pixel[GREEN_LSB +: CH_W]);
      blue_nxt  = blue_r  + SUM_W'(pixel[BLUE_LSB  +: CH_W]);
      cnt_nxt   = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      cnt_r   <= '0;
    end else begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign st.box_full = (cnt_r >= area);
  assign red_sum     = red_r;
  assign green_sum   = green_r;
  assign blue_sum    = blue_r;
  assign count       = cnt_r;

  a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.add && ctrl.clear))
    else $error("bavg_acc: add and clear in the same cycle");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (cnt_r == '0 && red_r == '0 && green_r == '0 && blue_r == '0))
    else $error("bavg_acc: sums not cleared");

endmodule

FILE: hw/rtl/bavg_div.sv
// Shared restoring divider, one quotient bit per cycle, 5-bit quotient.
// Depends on bavg_pkg. Caller guarantees dividend < 32 * divisor.
`timescale 1ns / 1ps

module bavg_div #(
  parameter int DVD_W = 15,
  parameter int DVS_W = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DVD_W-1:0]            dividend,
  input  logic [DVS_W-1:0]            divisor,
  output bavg_pkg::div_status_t       st,
  output logic [bavg_pkg::QUO_W-1:0]  quotient
);
  import bavg_pkg::*;

  localparam int RW = DVS_W + QUO_W;

  logic [RW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = RW'(dividend);
      dsh_nxt  = RW'(divisor) << (QUO_W - 1);
      q_nxt    = '0;
      step_nxt = STEP_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[QUO_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign st.busy  = busy_r;
  assign st.done  = done_r;
  assign quotient = q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("bavg_div: start while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("bavg_div: done without a finished run");

endmodule

FILE: hw/rtl/box_average_rgb565_to_rgb555_unit.sv
// Top level of the box-average RGB565 to RGB555 unit: sequencer, config, output register.
// Depends on bavg_pkg, bavg_acc, bavg_div.
`timescale 1ns / 1ps

// Averages square boxes of cfg_wr_data by cfg_wr_data RGB565 words (0 acts as 1, values
// above MAX_BOX_SIDE saturate) into one RGB555 word. One word is taken at a time: a
// word that does not close its box passes through S_ACC and S_CHK back to S_IDLE; the
// word that closes a box also enters S_DIV, where one shared restoring divider yielding one
// quotient bit per cycle runs once per channel (red, green, blue). The result sits
// in an output register; if it has not been taken when the next box finishes, the unit
// waits there. Write cfg only while idle; a side change mid-box keeps the partial sums.

module box_average_rgb565_to_rgb555_unit #(
  parameter int MAX_BOX_SIDE = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bavg_pkg::SIDE_CFG_W-1:0]    cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bavg_pkg::PIX_IN_W-1:0]      in_source_pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bavg_pkg::PIX_OUT_W-1:0]     out_average_pixel
);
  import bavg_pkg::*;

  localparam int SUM_W = $clog2(31*MAX_BOX_SIDE*MAX_BOX_SIDE+1);
  localparam int CNT_W = $clog2(MAX_BOX_SIDE*MAX_BOX_SIDE+1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_CHK  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  // S_DIV also covers waiting for the output register once blue is done

  state_t                 state_r, state_nxt;
  chan_t                  ch_r, ch_nxt;
  logic [SIDE_CFG_W-1:0]  side_r;
  logic [PIX_IN_W-1:0]    pix_r;
  logic [PIX_OUT_W-1:0]   res_r, res_nxt;
  logic                   res_full_r, res_full_nxt;
  logic [PIX_OUT_W-1:0]   out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  acc_ctrl_t              acc_ctrl;
  acc_status_t            acc_st;
  logic [SUM_W-1:0]       red_sum, green_sum, blue_sum;
  logic [CNT_W-1:0]       count;

  logic                   div_start;
  logic [SUM_W-1:0]       div_dividend;
  div_status_t            div_st;
  logic [QUO_W-1:0]       div_q;

  logic                   in_acc;
  logic                   out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid_r && out_ready;

  bavg_acc #(
    .MAX_BOX_SIDE (MAX_BOX_SIDE)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (acc_ctrl),
    .pixel     (pix_r),
    .box_side  (side_r),
    .st        (acc_st),
    .red_sum   (red_sum),
    .green_sum (green_sum),
    .blue_sum  (blue_sum),
    .count     (count)
  );

  bavg_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .st       (div_st),
    .quotient (div_q)
  );

  always_comb begin
    case (ch_nxt)
      CH_RED:   div_dividend = red_sum;
      CH_GREEN: div_dividend = green_sum;
      CH_BLUE:  div_dividend = blue_sum;
      default:  div_dividend = red_sum;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    res_nxt       = res_r;
    res_full_nxt  = res_full_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    acc_ctrl      = '0;
    div_start     = 1'b0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        // ready is always high here
        if (in_valid) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        acc_ctrl.add = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (acc_st.box_full) begin
          ch_nxt    = CH_RED;
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          case (ch_r)
            CH_RED: begin
              res_nxt[OUT_RED_LSB +: CH_W] = div_q;
              ch_nxt    = CH_GREEN;
              div_start = 1'b1;
            end
            CH_GREEN: begin
              res_nxt[OUT_GREEN_LSB +: CH_W] = div_q;
              ch_nxt    = CH_BLUE;
              div_start = 1'b1;
            end
            default: begin
              res_nxt[OUT_BLUE_LSB +: CH_W] = div_q;
              res_full_nxt = 1'b1;
            end
          endcase
        end
        // hand the finished word to the output register when it is free
        if (res_full_r && (!out_valid_r || out_ready)) begin
          out_nxt        = res_r;
          out_valid_nxt  = 1'b1;
          res_full_nxt   = 1'b0;
          acc_ctrl.clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= CH_RED;
      side_r      <= SIDE_CFG_W'(1);
      res_full_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      res_full_r  <= res_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        side_r <= cfg_wr_data;
      end
    end
    if (in_acc) begin
      pix_r <= in_source_pixel;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_average_pixel = out_r;

  a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ACC))
    else $error("top: accepted word not accumulated");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("top: divider finished outside the divide phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("top: pending result overwritten");

endmodule
